// ===== rtl/abioc_pkg.sv =====
// Shared types and constants of the arcade board I/O controller.
package abioc_pkg;

    // Request kinds
    localparam logic [2:0] ACT_MAIN_WRITE  = 3'd0;
    localparam logic [2:0] ACT_MAIN_READ   = 3'd1;
    localparam logic [2:0] ACT_SOUND_WRITE = 3'd2;
    localparam logic [2:0] ACT_SOUND_READ  = 3'd3;
    localparam logic [2:0] ACT_FRAME_TICK  = 3'd4;
    localparam logic [2:0] ACT_LINE_TICK   = 3'd5;

    // Main CPU write map
    localparam logic [15:0] ADDR_SOUND_IRQ  = 16'h2002;
    localparam logic [15:0] ADDR_FLIP       = 16'h2006;
    localparam logic [15:0] ADDR_IRQ_ENABLE = 16'h2007;
    localparam logic [15:0] ADDR_WATCHDOG   = 16'h2100;
    localparam logic [15:0] ADDR_PAL_BANK   = 16'h2200;
    localparam logic [15:0] ADDR_LATCH      = 16'h2400;

    // Main CPU read map
    localparam logic [15:0] ADDR_IN_COIN    = 16'h2400;
    localparam logic [15:0] ADDR_IN_P1      = 16'h2401;
    localparam logic [15:0] ADDR_IN_P2      = 16'h2402;
    localparam logic [15:0] ADDR_DIP_C      = 16'h2403;
    localparam logic [15:0] ADDR_DIP_A      = 16'h2500;
    localparam logic [15:0] ADDR_DIP_B      = 16'h2501;

    // Sound CPU map
    localparam logic [15:0] ADDR_CHIP0      = 16'h8002;
    localparam logic [15:0] ADDR_SND_LATCH  = 16'h8003;
    localparam logic [15:0] ADDR_CHIP1      = 16'h8004;
    localparam logic [15:0] ADDR_TIMER      = 16'h8005;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_DIP_A = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIP_B = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DIP_C = 2'd2;

    // DIP switch reset values
    localparam logic [7:0] DIP_A_RESET = 8'hff;
    localparam logic [7:0] DIP_B_RESET = 8'h7b;
    localparam logic [7:0] DIP_C_RESET = 8'hfe;

    typedef struct packed {
        logic [2:0]  action;
        logic [15:0] address;
        logic [7:0]  data;
        logic [7:0]  coin_buttons;
        logic [7:0]  player_one_buttons;
        logic [7:0]  player_two_buttons;
        logic [31:0] sound_cycle_count;
        logic [7:0]  scanline;
    } req_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       main_irq;
        logic       snd_irq_level;
        logic       sound_chip_write;
        logic       sound_chip_select;
        logic [7:0] sound_chip_data;
        logic       flip_screen;
        logic [6:0] pal_offset;
        logic       reset_request;
    } rsp_t;

endpackage

// ===== rtl/arcade_board_io_controller_unit.sv =====
// Top level of the arcade board I/O controller: bus decode, latches, watchdog and IRQs.
//
// Each request (a main or sound CPU bus access, a frame tick or a scanline tick) is
// decoded combinationally against the board latches, which update at the edge that
// accepts it; its result goes to an output register backed by one skid entry, so a
// new request is taken every cycle while the result side keeps up, and one more is
// taken after the result side stalls. The rate is one request per clock while the
// result side keeps up. Results follow requests in order through the registered
// output. DIP switch registers are written through the cfg port, which is always
// ready; indexes beyond the third register are ignored.
module arcade_board_io_controller_unit #(
    parameter logic [6:0] WATCHDOG_FRAMES = 7'd120,
    parameter logic [7:0] IRQ_SCANLINE    = 8'd240
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                req_valid,
    output logic                                req_stall,
    input  abioc_pkg::req_t                     req,
    output logic                                rsp_valid,
    input  logic                                rsp_stall,
    output abioc_pkg::rsp_t                     rsp,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [abioc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [7:0]                          cfg_data
);

    // DIP switches
    logic [7:0] dip_a_reg, dip_b_reg, dip_c_reg;

    // Board latches
    logic [7:0] sound_latch_reg,  sound_latch_next;
    logic       flip_reg,         flip_next;
    logic [2:0] bank_reg,         bank_next;
    logic       vblank_en_reg,    vblank_en_next;
    logic [7:0] snd_irq_reg_reg,  snd_irq_reg_next;
    logic       snd_irq_line_reg, snd_irq_line_next;
    logic [6:0] watchdog_reg,     watchdog_next;
    logic [7:0] port_coin_reg,    port_coin_next;
    logic [7:0] port_p1_reg,      port_p1_next;
    logic [7:0] port_p2_reg,      port_p2_next;

    logic            accept;
    logic [6:0]      wd_inc;
    abioc_pkg::rsp_t result;

    assign cfg_ready = 1'b1;
    assign accept    = req_valid && !req_stall;
    assign wd_inc    = watchdog_reg + 7'd1;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dip_a_reg <= abioc_pkg::DIP_A_RESET;
            dip_b_reg <= abioc_pkg::DIP_B_RESET;
            dip_c_reg <= abioc_pkg::DIP_C_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == abioc_pkg::CFG_DIP_A)
                dip_a_reg <= cfg_data;
            if (cfg_index == abioc_pkg::CFG_DIP_B)
                dip_b_reg <= cfg_data;
            if (cfg_index == abioc_pkg::CFG_DIP_C)
                dip_c_reg <= cfg_data;
        end
    end

    // Request decode: next latch state and result
    always_comb
    begin
        sound_latch_next  = sound_latch_reg;
        flip_next         = flip_reg;
        bank_next         = bank_reg;
        vblank_en_next    = vblank_en_reg;
        snd_irq_reg_next  = snd_irq_reg_reg;
        snd_irq_line_next = snd_irq_line_reg;
        watchdog_next     = watchdog_reg;
        port_coin_next    = port_coin_reg;
        port_p1_next      = port_p1_reg;
        port_p2_next      = port_p2_reg;
        result            = '0;

        unique case (req.action)
            abioc_pkg::ACT_MAIN_WRITE:
            begin
                unique case (req.address)
                    abioc_pkg::ADDR_SOUND_IRQ:
                    begin
                        // 0 -> 1 transition raises the sound IRQ
                        if (snd_irq_reg_reg == 8'd0 && req.data == 8'd1)
                            snd_irq_line_next = 1'b1;
                        snd_irq_reg_next = req.data;
                    end
                    abioc_pkg::ADDR_FLIP:       flip_next        = req.data[0];
                    abioc_pkg::ADDR_IRQ_ENABLE: vblank_en_next   = req.data[0];
                    abioc_pkg::ADDR_WATCHDOG:   watchdog_next    = 7'd0;
                    abioc_pkg::ADDR_PAL_BANK:   bank_next        = req.data[2:0];
                    abioc_pkg::ADDR_LATCH:      sound_latch_next = req.data;
                    default: ;
                endcase
            end
            abioc_pkg::ACT_MAIN_READ:
            begin
                unique case (req.address)
                    abioc_pkg::ADDR_IN_COIN: result.read_data = port_coin_reg;
                    abioc_pkg::ADDR_IN_P1:   result.read_data = port_p1_reg;
                    abioc_pkg::ADDR_IN_P2:   result.read_data = port_p2_reg;
                    abioc_pkg::ADDR_DIP_C:   result.read_data = dip_c_reg;
                    abioc_pkg::ADDR_DIP_A:   result.read_data = dip_a_reg;
                    abioc_pkg::ADDR_DIP_B:   result.read_data = dip_b_reg;
                    default:                 result.read_data = 8'd0;
                endcase
            end
            abioc_pkg::ACT_SOUND_WRITE:
            begin
                if (req.address == abioc_pkg::ADDR_CHIP0 ||
                    req.address == abioc_pkg::ADDR_CHIP1)
                begin
                    result.sound_chip_write  = 1'b1;
                    result.sound_chip_select = req.address[2];
                    result.sound_chip_data   = req.data;
                end
            end
            abioc_pkg::ACT_SOUND_READ:
            begin
                if (req.address == abioc_pkg::ADDR_SND_LATCH)
                begin
                    // latch read acknowledges the sound IRQ
                    snd_irq_line_next = 1'b0;
                    result.read_data  = sound_latch_reg;
                end
                else if (req.address == abioc_pkg::ADDR_TIMER)
                begin
                    // cycle count / 512, low byte
                    result.read_data = req.sound_cycle_count[16:9];
                end
            end
            abioc_pkg::ACT_FRAME_TICK:
            begin
                if (wd_inc == WATCHDOG_FRAMES)
                begin
                    watchdog_next        = 7'd0;
                    result.reset_request = 1'b1;
                end
                else
                begin
                    watchdog_next = wd_inc;
                end
                port_coin_next = ~req.coin_buttons;
                port_p1_next   = ~req.player_one_buttons;
                port_p2_next   = ~req.player_two_buttons;
            end
            abioc_pkg::ACT_LINE_TICK:
            begin
                result.main_irq = (req.scanline == IRQ_SCANLINE) && vblank_en_reg;
            end
            default: ;
        endcase

        // Status fields reflect the state after this request
        result.snd_irq_level = snd_irq_line_next;
        result.flip_screen   = flip_next;
        result.pal_offset    = {bank_next, 4'b0000};
    end

    // Latch state, updated on each accepted request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sound_latch_reg  <= 8'd0;
            flip_reg         <= 1'b0;
            bank_reg         <= 3'd0;
            vblank_en_reg    <= 1'b0;
            snd_irq_reg_reg  <= 8'd0;
            snd_irq_line_reg <= 1'b0;
            watchdog_reg     <= 7'd0;
            port_coin_reg    <= 8'hff;
            port_p1_reg      <= 8'hff;
            port_p2_reg      <= 8'hff;
        end
        else if (accept)
        begin
            sound_latch_reg  <= sound_latch_next;
            flip_reg         <= flip_next;
            bank_reg         <= bank_next;
            vblank_en_reg    <= vblank_en_next;
            snd_irq_reg_reg  <= snd_irq_reg_next;
            snd_irq_line_reg <= snd_irq_line_next;
            watchdog_reg     <= watchdog_next;
            port_coin_reg    <= port_coin_next;
            port_p1_reg      <= port_p1_next;
            port_p2_reg      <= port_p2_next;
        end
    end

    // Result register and skid entry
    abioc_skid #(
        .WIDTH ($bits(abioc_pkg::rsp_t))
    ) u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req_valid),
        .in_stall  (req_stall),
        .in_data   (result),
        .out_valid (rsp_valid),
        .out_stall (rsp_stall),
        .out_data  (rsp)
    );

endmodule

// ===== rtl/abioc_skid.sv =====
// Output register with a skid stage between the decode logic and the result channel.
module abioc_skid #(
    parameter int unsigned WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [WIDTH-1:0] out_data
);

    logic             out_valid_reg, out_valid_next;
    logic [WIDTH-1:0] out_data_reg,  out_data_next;
    logic             skid_valid_reg, skid_valid_next;
    logic [WIDTH-1:0] skid_data_reg,  skid_data_next;
    logic             push;
    logic             out_free;

    assign in_stall  = skid_valid_reg;
    assign push      = in_valid && !skid_valid_reg;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Refill the output from the skid entry first, else straight from the input
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = push;
                out_data_next  = in_data;
            end
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = in_data;
        end
    end

    // Control flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule
